### rtl/sdssf_pkg.sv
package sdssf_pkg;

    localparam int MAX_DIGITS_DEF = 8;
    localparam int PADDR_W        = 4;
    localparam int PDATA_W        = 32;

    // register indexes (byte address bits [3:2])
    localparam logic [1:0] REG_DIGIT_COUNT = 2'd0;
    localparam logic [1:0] REG_FILL_CHAR   = 2'd1;
    localparam logic [1:0] REG_HIGH_FIRST  = 2'd2;

    localparam logic [3:0] DIGIT_COUNT_RST = 4'd4;
    localparam logic [7:0] FILL_CHAR_RST   = 8'h20;
    localparam logic       HIGH_FIRST_RST  = 1'b1;

    localparam logic [6:0] SEG_BLANK = 7'h00;
    localparam logic [6:0] SEG_DASH  = 7'h40;
    localparam logic [6:0] SEG_E     = 7'h79;

    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_UP_A  = 8'h41;
    localparam logic [7:0] CH_UP_Z  = 8'h5A;
    localparam logic [7:0] CH_LO_A  = 8'h61;
    localparam logic [7:0] CH_LO_Z  = 8'h7A;
    localparam logic [7:0] CH_DASH  = 8'h2D;

    typedef struct packed {
        logic neg;
        logic ok;
    } sdssf_tag_t;

    // bits needed to hold 10^d - 1; elaboration only
    function automatic int bin_bits(input int d);
        longint p;
        int     w;
        p = 1;
        w = 0;
        for (int i = 0; i < d; i++)
            p = p * 10;
        while ((longint'(1) << w) < p)
            w++;
        return w;
    endfunction

    function automatic logic [31:0] pow10(input logic [3:0] n);
        logic [31:0] r;
        case (n)
            4'd0:    r = 32'd1;
            4'd1:    r = 32'd10;
            4'd2:    r = 32'd100;
            4'd3:    r = 32'd1000;
            4'd4:    r = 32'd10000;
            4'd5:    r = 32'd100000;
            4'd6:    r = 32'd1000000;
            4'd7:    r = 32'd10000000;
            4'd8:    r = 32'd100000000;
            4'd9:    r = 32'd1000000000;
            default: r = 32'hFFFF_FFFF;
        endcase
        return r;
    endfunction

    function automatic logic [6:0] digit_seg(input logic [3:0] d);
        logic [6:0] s;
        case (d)
            4'd0:    s = 7'h3F;
            4'd1:    s = 7'h06;
            4'd2:    s = 7'h5B;
            4'd3:    s = 7'h4F;
            4'd4:    s = 7'h66;
            4'd5:    s = 7'h6D;
            4'd6:    s = 7'h7D;
            4'd7:    s = 7'h07;
            4'd8:    s = 7'h7F;
            4'd9:    s = 7'h6F;
            default: s = SEG_BLANK;
        endcase
        return s;
    endfunction

    function automatic logic [6:0] letter_seg(input logic [4:0] l);
        logic [6:0] s;
        case (l)
            5'd0:    s = 7'h77;
            5'd1:    s = 7'h7C;
            5'd2:    s = 7'h39;
            5'd3:    s = 7'h5E;
            5'd4:    s = 7'h79;
            5'd5:    s = 7'h71;
            5'd6:    s = 7'h7D;
            5'd7:    s = 7'h76;
            5'd8:    s = 7'h06;
            5'd9:    s = 7'h1F;
            5'd11:   s = 7'h38;
            5'd12:   s = 7'h37;
            5'd13:   s = 7'h54;
            5'd14:   s = 7'h5C;
            5'd15:   s = 7'h73;
            5'd16:   s = 7'h67;
            5'd17:   s = 7'h50;
            5'd18:   s = 7'h6D;
            5'd19:   s = 7'h78;
            5'd20:   s = 7'h1C;
            5'd21:   s = 7'h3E;
            5'd24:   s = 7'h6E;
            5'd25:   s = 7'h5B;
            default: s = SEG_BLANK;
        endcase
        return s;
    endfunction

    // ASCII to segments; unsupported characters are blank
    function automatic logic [6:0] char_seg(input logic [7:0] ch);
        logic [7:0] off;
        logic [6:0] s;
        s   = SEG_BLANK;
        off = '0;
        if (ch >= CH_ZERO && ch <= CH_NINE)
        begin
            off = ch - CH_ZERO;
            s   = digit_seg(off[3:0]);
        end
        else if (ch >= CH_UP_A && ch <= CH_UP_Z)
        begin
            off = ch - CH_UP_A;
            s   = letter_seg(off[4:0]);
        end
        else if (ch >= CH_LO_A && ch <= CH_LO_Z)
        begin
            off = ch - CH_LO_A;
            s   = letter_seg(off[4:0]);
        end
        else if (ch == CH_DASH)
        begin
            s = SEG_DASH;
        end
        return s;
    endfunction

endpackage

### rtl/sdssf_if.sv
interface sdssf_in_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] value;

    modport source (output valid, output value, input ready);
    modport sink   (input valid, input value, output ready);
endinterface

interface sdssf_out_if;
    logic       valid;
    logic       ready;
    logic [6:0] segments;
    logic       last;

    modport source (output valid, output segments, output last, input ready);
    modport sink   (input valid, input segments, input last, output ready);
endinterface

### rtl/sdssf_bcd_conv.sv
module sdssf_bcd_conv #(
    parameter int MAX_DIGITS = sdssf_pkg::MAX_DIGITS_DEF,
    localparam int BIN_W = sdssf_pkg::bin_bits(MAX_DIGITS),
    localparam int BCD_W = 4 * MAX_DIGITS
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     en,
    input  logic                     vld_in,
    input  logic [BIN_W-1:0]         bin_in,
    input  sdssf_pkg::sdssf_tag_t    tag_in,
    output logic                     vld_out,
    output logic [BCD_W-1:0]         bcd_out,
    output sdssf_pkg::sdssf_tag_t    tag_out
);
    import sdssf_pkg::*;

    // double dabble, up to eight shift steps per stage
    localparam int STEPS = 8;
    localparam int NST   = (BIN_W + STEPS - 1) / STEPS;

    logic             stg_vld [NST+1];
    logic [BCD_W-1:0] stg_bcd [NST+1];
    logic [BIN_W-1:0] stg_bin [NST+1];
    sdssf_tag_t       stg_tag [NST+1];

    logic             vld_reg [NST];
    logic [BCD_W-1:0] bcd_reg [NST];
    logic [BIN_W-1:0] bin_reg [NST];
    sdssf_tag_t       tag_reg [NST];
    logic [BCD_W-1:0] bcd_next [NST];
    logic [BIN_W-1:0] bin_next [NST];

    assign stg_vld[0] = vld_in;
    assign stg_bcd[0] = '0;
    assign stg_bin[0] = bin_in;
    assign stg_tag[0] = tag_in;

    for (genvar s = 0; s < NST; s++)
    begin : g_stage
        localparam int FIRST = s * STEPS;
        localparam int NSTEP = (BIN_W - FIRST < STEPS) ? (BIN_W - FIRST) : STEPS;

        logic [BCD_W-1:0] b;
        logic [BIN_W-1:0] r;

        always_comb
        begin
            b = stg_bcd[s];
            r = stg_bin[s];
            for (int k = 0; k < NSTEP; k++)
            begin
                for (int d = 0; d < MAX_DIGITS; d++)
                begin
                    if (b[4*d +: 4] >= 4'd5)
                        b[4*d +: 4] = b[4*d +: 4] + 4'd3;
                end
                {b, r} = {b, r} << 1;
            end
            bcd_next[s] = b;
            bin_next[s] = r;
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                vld_reg[s] <= 1'b0;
            else if (en)
                vld_reg[s] <= stg_vld[s];
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                bcd_reg[s] <= bcd_next[s];
                bin_reg[s] <= bin_next[s];
                tag_reg[s] <= stg_tag[s];
            end
        end

        assign stg_vld[s+1] = vld_reg[s];
        assign stg_bcd[s+1] = bcd_reg[s];
        assign stg_bin[s+1] = bin_reg[s];
        assign stg_tag[s+1] = tag_reg[s];
    end

    assign vld_out = stg_vld[NST];
    assign bcd_out = stg_bcd[NST];
    assign tag_out = stg_tag[NST];

endmodule

### rtl/signed_decimal_seven_segment_formatter_unit.sv
// Signed decimal to seven-segment formatter. Each 32-bit signed value taken on din
// comes out on dout as a run of digit_count seven-bit segment codes (bit 0 = segment a),
// last set on the final code of the run; digit_count 0 acts as 1 and values above
// MAX_DIGITS clamp. Non-negative values below 10^n show their digits with fill_char
// above the top nonzero digit, negatives above -10^(n-1) add one dash, anything else
// shows 'E' at the top position over blanks. A number of n positions occupies the
// output for n transfers, as the single output port moves one position per transfer;
// the pipeline holds further numbers while the serialiser is busy with a run, and for
// n = 1 a new number can go out every cycle while the sink is ready. The path from the
// input transfer to the first position runs through abs, range check, double dabble
// stages of up to eight shifts each, segment formatting, serialiser and output
// register. Registers are at byte addresses 0
// (digit_count), 4 (fill_char) and 8 (high_digit_first) and are to be written only
// while the block is idle.
module signed_decimal_seven_segment_formatter_unit #(
    parameter int MAX_DIGITS = sdssf_pkg::MAX_DIGITS_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    sdssf_in_if.sink                        din,
    sdssf_out_if.source                     dout,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [sdssf_pkg::PADDR_W-1:0]   paddr,
    input  logic [sdssf_pkg::PDATA_W-1:0]   pwdata,
    output logic [sdssf_pkg::PDATA_W-1:0]   prdata,
    output logic                            pready
);
    import sdssf_pkg::*;

    localparam int BIN_W = bin_bits(MAX_DIGITS);
    localparam int BCD_W = 4 * MAX_DIGITS;
    localparam int CNT_W = $clog2(MAX_DIGITS + 1);
    localparam int IDX_W = (MAX_DIGITS > 1) ? $clog2(MAX_DIGITS) : 1;

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [3:0] digit_count_reg;
    logic [7:0] fill_char_reg;
    logic       high_first_reg;
    logic       cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            digit_count_reg <= DIGIT_COUNT_RST;
            fill_char_reg   <= FILL_CHAR_RST;
            high_first_reg  <= HIGH_FIRST_RST;
        end
        else if (cfg_wr)
        begin
            case (paddr[3:2])
                REG_DIGIT_COUNT: digit_count_reg <= pwdata[3:0];
                REG_FILL_CHAR:   fill_char_reg   <= pwdata[7:0];
                REG_HIGH_FIRST:  high_first_reg  <= pwdata[0];
                default:         ;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[3:2])
            REG_DIGIT_COUNT: prdata = {{(PDATA_W-4){1'b0}}, digit_count_reg};
            REG_FILL_CHAR:   prdata = {{(PDATA_W-8){1'b0}}, fill_char_reg};
            REG_HIGH_FIRST:  prdata = {{(PDATA_W-1){1'b0}}, high_first_reg};
            default:         prdata = '0;
        endcase
    end

    // effective position count, clamped to 1..MAX_DIGITS
    logic [CNT_W-1:0] n_eff;
    logic [IDX_W-1:0] n_m1;

    always_comb
    begin
        if (digit_count_reg == 4'd0)
            n_eff = CNT_W'(1);
        else if (digit_count_reg > 4'(MAX_DIGITS))
            n_eff = CNT_W'(MAX_DIGITS);
        else
            n_eff = CNT_W'(digit_count_reg);
        n_m1 = IDX_W'(n_eff - CNT_W'(1));
    end

    // ------------------------------------------------------------------
    // Pipeline: one global advance, held while the format stage holds a number and the serialiser is busy
    // ------------------------------------------------------------------
    logic pipe_en;
    logic ser_take;
    logic fmt_valid_reg;

    assign pipe_en   = ser_take || !fmt_valid_reg;
    assign din.ready = pipe_en;

    // stage 1: sign and magnitude
    logic        s1_valid_reg;
    logic        s1_neg_reg;
    logic [31:0] s1_mag_reg;
    logic [31:0] s1_mag_next;
    logic [31:0] vin;

    assign vin         = din.value;
    assign s1_mag_next = vin[31] ? (~vin + 32'd1) : vin;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else if (pipe_en)
            s1_valid_reg <= din.valid;
    end

    always_ff @(posedge clk)
    begin
        if (pipe_en)
        begin
            s1_neg_reg <= vin[31];
            s1_mag_reg <= s1_mag_next;
        end
    end

    // stage 2: range check against 10^n (10^(n-1) for negatives)
    logic             s2_valid_reg;
    sdssf_tag_t       s2_tag_reg;
    sdssf_tag_t       s2_tag_next;
    logic [BIN_W-1:0] s2_bin_reg;
    logic [31:0]      lim;

    always_comb
    begin
        lim = s1_neg_reg ? pow10(4'(n_m1)) : pow10(4'(n_eff));
        s2_tag_next.neg = s1_neg_reg;
        s2_tag_next.ok  = s1_mag_reg < lim;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s2_valid_reg <= 1'b0;
        else if (pipe_en)
            s2_valid_reg <= s1_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (pipe_en)
        begin
            s2_tag_reg <= s2_tag_next;
            s2_bin_reg <= s1_mag_reg[BIN_W-1:0];
        end
    end

    // binary to BCD stages
    logic             dd_valid;
    logic [BCD_W-1:0] dd_bcd;
    sdssf_tag_t       dd_tag;

    sdssf_bcd_conv #(
        .MAX_DIGITS (MAX_DIGITS)
    ) u_bcd (
        .clk     (clk),
        .rst_n   (rst_n),
        .en      (pipe_en),
        .vld_in  (s2_valid_reg),
        .bin_in  (s2_bin_reg),
        .tag_in  (s2_tag_reg),
        .vld_out (dd_valid),
        .bcd_out (dd_bcd),
        .tag_out (dd_tag)
    );

    // format stage: one segment code per position, units at index 0
    logic [6:0] fmt_seg_reg  [MAX_DIGITS];
    logic [6:0] fmt_seg_next [MAX_DIGITS];
    logic [MAX_DIGITS:0] nz;      // some digit at or above this position is nonzero
    logic [MAX_DIGITS-1:0] shown;
    logic [6:0] fill_seg;

    assign fill_seg = char_seg(fill_char_reg);

    always_comb
    begin
        nz[MAX_DIGITS] = 1'b0;
        for (int i = MAX_DIGITS - 1; i >= 0; i--)
            nz[i] = (dd_bcd[4*i +: 4] != 4'd0) || nz[i+1];
        for (int i = 0; i < MAX_DIGITS; i++)
            shown[i] = (i == 0) || nz[i];
        for (int i = 0; i < MAX_DIGITS; i++)
        begin
            if (!dd_tag.ok)
                fmt_seg_next[i] = (IDX_W'(i) == n_m1) ? SEG_E : SEG_BLANK;
            else if (shown[i])
                fmt_seg_next[i] = digit_seg(dd_bcd[4*i +: 4]);
            else if (dd_tag.neg && (i > 0) && shown[(i > 0) ? i - 1 : 0])
                fmt_seg_next[i] = SEG_DASH;
            else
                fmt_seg_next[i] = fill_seg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            fmt_valid_reg <= 1'b0;
        else if (pipe_en)
            fmt_valid_reg <= dd_valid;
    end

    always_ff @(posedge clk)
    begin
        if (pipe_en)
            fmt_seg_reg <= fmt_seg_next;
    end

    // ------------------------------------------------------------------
    // Serialiser: walks the positions, one transfer each
    // ------------------------------------------------------------------
    logic             ser_valid_reg;
    logic             ser_valid_next;
    logic [IDX_W-1:0] ser_idx_reg;
    logic [IDX_W-1:0] ser_idx_next;
    logic [6:0]       ser_seg_reg [MAX_DIGITS];
    logic             ser_last;
    logic             ser_emit;
    logic [IDX_W-1:0] pos;

    logic       out_valid_reg;
    logic       out_valid_next;
    logic [6:0] out_seg_reg;
    logic       out_last_reg;
    logic       out_load;

    assign out_load = !out_valid_reg || dout.ready;
    assign ser_emit = ser_valid_reg && out_load;
    assign ser_last = ser_idx_reg == n_m1;
    assign ser_take = !ser_valid_reg || (ser_emit && ser_last);
    assign pos      = high_first_reg ? (n_m1 - ser_idx_reg) : ser_idx_reg;

    always_comb
    begin
        ser_valid_next = ser_valid_reg;
        ser_idx_next   = ser_idx_reg;
        if (ser_take)
        begin
            ser_valid_next = fmt_valid_reg;
            ser_idx_next   = '0;
        end
        else if (ser_emit)
        begin
            ser_idx_next = ser_idx_reg + IDX_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ser_valid_reg <= 1'b0;
            ser_idx_reg   <= '0;
        end
        else
        begin
            ser_valid_reg <= ser_valid_next;
            ser_idx_reg   <= ser_idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ser_take && fmt_valid_reg)
            ser_seg_reg <= fmt_seg_reg;
    end

    // output register parts the serialiser from the sink
    assign out_valid_next = out_load ? ser_valid_reg : out_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_seg_reg  <= ser_seg_reg[pos];
            out_last_reg <= ser_last;
        end
    end

    assign dout.valid    = out_valid_reg;
    assign dout.segments = out_seg_reg;
    assign dout.last     = out_last_reg;

`ifndef SYNTHESIS
    // position counter stays inside the run
    a_idx_in_run: assert property (@(posedge clk) disable iff (!rst_n)
        ser_valid_reg |-> (ser_idx_reg <= n_m1))
        else $error("serialiser index beyond run length");

    // the pipeline only holds while the serialiser has a run in hand
    a_stall_busy: assert property (@(posedge clk) disable iff (!rst_n)
        !pipe_en |-> (ser_valid_reg && fmt_valid_reg))
        else $error("pipeline stalled with idle serialiser");

    // an accepted input occupies the first stage next cycle
    a_in_capture: assert property (@(posedge clk) disable iff (!rst_n)
        (din.valid && din.ready) |=> s1_valid_reg)
        else $error("input transfer lost at first stage");
`endif

endmodule
